@@ hdl/vrap_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Video RAM access port package
// Shared constants, access codes and the memory control bundle.
// ----------------------------------------------------------------------------
package vrap_pkg;

    // Default number of 16-bit words in the video memory.
    localparam int VRAM_WORDS_DEFAULT = 32768;

    // Width of the CPU-visible word address and of one memory word.
    localparam int WORD_ADDR_W = 16;
    localparam int WORD_W      = 16;
    localparam int BYTE_W      = 8;

    // Access codes carried on the mode field of a transaction.
    typedef enum logic [2:0] {
        MODE_CTRL    = 3'd0,
        MODE_ADDR_LO = 3'd1,
        MODE_ADDR_HI = 3'd2,
        MODE_WR_LO   = 3'd3,
        MODE_WR_HI   = 3'd4,
        MODE_RD_LO   = 3'd5,
        MODE_RD_HI   = 3'd6
    } mode_t;

    // Address remap codes from the control byte.
    typedef enum logic [1:0] {
        REMAP_NONE = 2'd0,
        REMAP_ROT8 = 2'd1,
        REMAP_ROT9 = 2'd2,
        REMAP_ROT10 = 2'd3
    } remap_t;

    // Bit positions inside the control byte.
    localparam int CTRL_STEP_LSB  = 0;
    localparam int CTRL_REMAP_LSB = 2;
    localparam int CTRL_HIGH_BIT  = 7;

    // Control bundle from the access logic to the memory.
    typedef struct packed {
        logic       rd_en;
        logic [1:0] byte_wr_en;
    } mem_ctrl_t;

    // Address increment selected by the step code: 1, 32, 128, 128.
    function automatic logic [WORD_ADDR_W-1:0] step_size(input logic [1:0] code);
        logic [WORD_ADDR_W-1:0] inc;
        unique case (code)
            2'd0:    inc = WORD_ADDR_W'(1);
            2'd1:    inc = WORD_ADDR_W'(32);
            default: inc = WORD_ADDR_W'(128);
        endcase
        return inc;
    endfunction

endpackage
`default_nettype wire

@@ hdl/vrap_remap.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Address remap
// Rotates the low address bits per the remap code and folds the result into
// the memory size.
// ----------------------------------------------------------------------------
module vrap_remap
    import vrap_pkg::*;
#(
    parameter int MEM_WORDS = VRAM_WORDS_DEFAULT
) (
    input  wire logic [WORD_ADDR_W-1:0]       word_addr,
    input  wire logic [1:0]                   remap,
    output logic      [$clog2(MEM_WORDS)-1:0] mem_addr
);

    localparam int ADDR_W   = $clog2(MEM_WORDS);
    localparam int QUO_BITS = $clog2((2**WORD_ADDR_W - 1) / MEM_WORDS + 1);
    localparam logic [WORD_ADDR_W:0] MOD_WORDS = (WORD_ADDR_W + 1)'(MEM_WORDS);

    logic [WORD_ADDR_W-1:0] rotated;
    logic [WORD_ADDR_W:0]   rem;

    always_comb begin
        unique case (remap_t'(remap))
            REMAP_ROT8:  rotated = {word_addr[15:8], word_addr[4:0], word_addr[7:5]};
            REMAP_ROT9:  rotated = {word_addr[15:9], word_addr[5:0], word_addr[8:6]};
            REMAP_ROT10: rotated = {word_addr[15:10], word_addr[6:0], word_addr[9:7]};
            default:     rotated = word_addr;
        endcase
    end

    // Restoring reduction: the quotient has only a few bits, one compare and
    // subtract per bit.
    always_comb begin
        rem = {1'b0, rotated};
        for (int k = QUO_BITS - 1; k >= 0; k--) begin
            if (rem >= (MOD_WORDS << k)) begin
                rem = rem - (MOD_WORDS << k);
            end
        end
    end

    assign mem_addr = rem[ADDR_W-1:0];

endmodule
`default_nettype wire

@@ hdl/vrap_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Video memory
// Single-port word memory with byte write enables and a registered read.
// ----------------------------------------------------------------------------
module vrap_mem
    import vrap_pkg::*;
#(
    parameter int MEM_WORDS = VRAM_WORDS_DEFAULT
) (
    input  wire logic                         aclk,
    input  wire mem_ctrl_t                    ctrl,
    input  wire logic [$clog2(MEM_WORDS)-1:0] addr,
    input  wire logic [WORD_W-1:0]            wdata,
    output logic      [WORD_W-1:0]            rdata
);

    logic [WORD_W-1:0] mem [MEM_WORDS];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.byte_wr_en[0]) begin
            mem[addr][BYTE_W-1:0] <= wdata[BYTE_W-1:0];
        end
        if (ctrl.byte_wr_en[1]) begin
            mem[addr][WORD_W-1:BYTE_W] <= wdata[WORD_W-1:BYTE_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ hdl/video_ram_access_port.sv @@
// ----------------------------------------------------------------------------
// Video RAM access port
// Path: a transaction goes from the input register to the result register.
// Throughput: one transaction per cycle when the result channel is not stalled.
// Reset: synchronous, active low; after release the memory is cleared word by
// word from the first to the last, during which s_ready stays low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module video_ram_access_port
    import vrap_pkg::*;
#(
    parameter int MEM_WORDS = VRAM_WORDS_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Input channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [2:0]        s_mode,
    input  wire logic [BYTE_W-1:0] s_data,
    input  wire logic              s_vram_accessible,
    // Result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [BYTE_W-1:0] m_read_data
);

    localparam int ADDR_W = $clog2(MEM_WORDS);
    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MEM_WORDS - 1);

    // ------------------------------------------------------------------
    // Input register. A transaction waits here, held while the result register
    // is full, while the access logic works on it against the current port state.
    // ------------------------------------------------------------------
    logic              in_valid_reg, in_valid_next;
    logic [2:0]        mode_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              ok_reg;

    // Port state.
    logic [WORD_ADDR_W-1:0] word_address_reg, word_address_next;
    logic [1:0]             step_code_reg, step_code_next;
    logic [1:0]             remap_reg, remap_next;
    logic                   step_on_high_reg, step_on_high_next;

    // The read latch lives either in prefetch_reg or, right after a memory
    // fetch, in the memory's own read register. pf_from_mem_reg tells which.
    // The memory read register only changes on a fetch, so it holds the
    // latch contents for as long as needed.
    logic [WORD_W-1:0] prefetch_reg, prefetch_next;
    logic              pf_from_mem_reg, pf_from_mem_next;
    logic [WORD_W-1:0] latch_word;

    // Result register.
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_read_data_reg, m_read_data_next;

    // Clearing pass after reset.
    logic              clearing_reg, clearing_next;
    logic [ADDR_W-1:0] clear_addr_reg, clear_addr_next;

    // Memory interface.
    mem_ctrl_t              mem_ctrl;
    logic [ADDR_W-1:0]      mem_addr;
    logic [ADDR_W-1:0]      access_index;
    logic [WORD_W-1:0]      mem_wdata;
    logic [WORD_W-1:0]      mem_rdata;
    logic [WORD_ADDR_W-1:0] access_address;

    // Access decode.
    logic exec_fire;
    logic do_fetch;
    logic do_advance;

    // A transaction is executed when the result register is free or is
    // being emptied in this same cycle.
    assign exec_fire = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !clearing_reg && (!in_valid_reg || exec_fire);

    assign latch_word = pf_from_mem_reg ? mem_rdata : prefetch_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg <= s_mode;
            data_reg <= s_data;
            ok_reg   <= s_vram_accessible;
        end
    end

    // ------------------------------------------------------------------
    // Access logic: one pass per transaction.
    // ------------------------------------------------------------------
    always_comb begin
        in_valid_next     = in_valid_reg;
        word_address_next = word_address_reg;
        step_code_next    = step_code_reg;
        remap_next        = remap_reg;
        step_on_high_next = step_on_high_reg;
        prefetch_next     = prefetch_reg;
        pf_from_mem_next  = pf_from_mem_reg;
        m_valid_next      = m_valid_reg;
        m_read_data_next  = m_read_data_reg;
        do_fetch          = 1'b0;
        do_advance        = 1'b0;
        mem_ctrl          = '0;
        access_address    = word_address_reg;

        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (exec_fire) begin
            in_valid_next = 1'b0;
        end

        if (exec_fire) begin
            m_valid_next     = 1'b1;
            m_read_data_next = '0;
            unique case (mode_reg)
                MODE_CTRL: begin
                    step_code_next    = data_reg[CTRL_STEP_LSB +: 2];
                    remap_next        = data_reg[CTRL_REMAP_LSB +: 2];
                    step_on_high_next = data_reg[CTRL_HIGH_BIT];
                end
                MODE_ADDR_LO: begin
                    word_address_next = {word_address_reg[WORD_ADDR_W-1:BYTE_W], data_reg};
                    access_address    = word_address_next;
                    do_fetch          = 1'b1;
                end
                MODE_ADDR_HI: begin
                    word_address_next = {data_reg, word_address_reg[BYTE_W-1:0]};
                    access_address    = word_address_next;
                    do_fetch          = 1'b1;
                end
                MODE_WR_LO: begin
                    mem_ctrl.byte_wr_en = {1'b0, ok_reg};
                    do_advance          = !step_on_high_reg;
                end
                MODE_WR_HI: begin
                    mem_ctrl.byte_wr_en = {ok_reg, 1'b0};
                    do_advance          = step_on_high_reg;
                end
                MODE_RD_LO: begin
                    m_read_data_next = latch_word[BYTE_W-1:0];
                    do_fetch         = !step_on_high_reg;
                    do_advance       = !step_on_high_reg;
                end
                MODE_RD_HI: begin
                    m_read_data_next = latch_word[WORD_W-1:BYTE_W];
                    do_fetch         = step_on_high_reg;
                    do_advance       = step_on_high_reg;
                end
                default: begin
                end
            endcase

            // A fetch while the memory is blocked loads zero instead.
            if (do_fetch) begin
                if (ok_reg) begin
                    mem_ctrl.rd_en   = 1'b1;
                    pf_from_mem_next = 1'b1;
                end else begin
                    prefetch_next    = '0;
                    pf_from_mem_next = 1'b0;
                end
            end

            if (do_advance) begin
                word_address_next = word_address_reg + step_size(step_code_reg);
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // The clearing pass owns the memory port; no transaction is taken
        // while it runs.
        if (clearing_reg) begin
            mem_ctrl.byte_wr_en = 2'b11;
        end
    end

    always_comb begin
        clearing_next   = clearing_reg;
        clear_addr_next = clear_addr_reg;
        if (clearing_reg) begin
            clear_addr_next = clear_addr_reg + ADDR_W'(1);
            if (clear_addr_reg == LAST_WORD) begin
                clearing_next = 1'b0;
            end
        end
    end

    assign mem_addr  = clearing_reg ? clear_addr_reg : access_index;
    assign mem_wdata = clearing_reg ? '0 : {data_reg, data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            word_address_reg <= '0;
            step_code_reg    <= '0;
            remap_reg        <= REMAP_NONE;
            step_on_high_reg <= 1'b0;
            prefetch_reg     <= '0;
            pf_from_mem_reg  <= 1'b0;
            m_valid_reg      <= 1'b0;
            clearing_reg     <= 1'b1;
            clear_addr_reg   <= '0;
        end else begin
            in_valid_reg     <= in_valid_next;
            word_address_reg <= word_address_next;
            step_code_reg    <= step_code_next;
            remap_reg        <= remap_next;
            step_on_high_reg <= step_on_high_next;
            prefetch_reg     <= prefetch_next;
            pf_from_mem_reg  <= pf_from_mem_next;
            m_valid_reg      <= m_valid_next;
            clearing_reg     <= clearing_next;
            clear_addr_reg   <= clear_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_read_data_reg <= m_read_data_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;

    // ------------------------------------------------------------------
    // Address remap and memory.
    // ------------------------------------------------------------------
    vrap_remap #(
        .MEM_WORDS(MEM_WORDS)
    ) u_remap (
        .word_addr(access_address),
        .remap    (remap_reg),
        .mem_addr (access_index)
    );

    vrap_mem #(
        .MEM_WORDS(MEM_WORDS)
    ) u_mem (
        .aclk (aclk),
        .ctrl (mem_ctrl),
        .addr (mem_addr),
        .wdata(mem_wdata),
        .rdata(mem_rdata)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_while_clearing: assert property (
        @(posedge aclk) disable iff (!aresetn) clearing_reg |-> !s_ready
    ) else $error("transaction accepted during the clearing pass");

    a_clear_done_stays: assert property (
        @(posedge aclk) disable iff (!aresetn) !clearing_reg |=> !clearing_reg
    ) else $error("clearing pass restarted without reset");

    a_exec_gives_result: assert property (
        @(posedge aclk) disable iff (!aresetn) exec_fire |=> m_valid_reg
    ) else $error("executed transaction produced no result");

    a_non_read_is_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        exec_fire && mode_reg != MODE_RD_LO && mode_reg != MODE_RD_HI
        |=> m_read_data_reg == '0
    ) else $error("non-read transaction returned nonzero data");

    a_latch_from_fetch: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(pf_from_mem_reg) |-> $past(mem_ctrl.rd_en)
    ) else $error("read latch switched to memory without a fetch");

    a_no_read_write_mix: assert property (
        @(posedge aclk) disable iff (!aresetn)
        mem_ctrl.rd_en |-> (mem_ctrl.byte_wr_en == 2'b00 && !clearing_reg)
    ) else $error("memory read collides with a write");

endmodule
`default_nettype wire
